FILE: rtl/sbd_pkg.sv
// shared types and constants of the sparse block decompressor
package sbd_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int VAL_W       = 8;
    localparam int RUN_W       = 11;
    localparam int LEN_W       = 16;
    localparam int BUF_W       = 16;
    localparam int CNT_W       = 5;
    localparam int NRES_W      = 4;
    localparam int MAX_RESULTS = 8;
    localparam int RUN_BITS    = 6;
    localparam int RUN_SHIFT   = 5;
    localparam int RUN_FLAG    = 5;
    localparam int TDATA_W     = 24;
    localparam int TUSER_W     = 2;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_EMIT  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_seq;

    // block phase
    typedef enum logic [2:0] {
        PH_HEAD   = 3'b001,
        PH_TABLE  = 3'b010,
        PH_STREAM = 3'b100
    } t_phase;

    // which bitstream field comes next
    typedef enum logic [2:0] {
        FS_INDEX  = 3'b001,
        FS_RUN_LO = 3'b010,
        FS_RUN_HI = 3'b100
    } t_field;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [RUN_W-1:0] run;
        logic             done;
        logic             err;
    } t_result;

endpackage

FILE: rtl/sparse_block_decompressor_unit.sv
// sparse block decompressor: header, value table and zero-run bitstream decode
// header and table beats are taken in the idle state; a bitstream beat is loaded, then each
// nonzero index passes scan, table look and emit, a zero index also reads its run field and
// any extended high part before emit, and a flush ends the beat; the one shared emit/length
// unit and the registered table read serve it all; s_axis_tready is low meanwhile
// i_rst_n is synchronous active low and clears control state; the value table is not cleared
module sparse_block_decompressor_unit
    import sbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // out_length register
    input  logic               i_cfg_wr_en,
    input  logic [LEN_W-1:0]   i_cfg_wr_data,
    // compressed byte stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] in_byte
    // decoded results
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [7:0] out_value, [18:8] zero_run, rest 0
    output logic [TUSER_W-1:0] m_axis_tuser,   // [0] block_done, [1] format_error
    output logic               m_axis_tlast    // last_of_item
);

    // number of significant bits of v
    function automatic logic [3:0] sig_bits(input logic [7:0] v);
        logic [3:0] b;
        b = 4'd0;
        for (int k = 0; k < 8; k++) begin
            if (v[k]) b = 4'(k + 1);
        end
        return b;
    endfunction

    // control and block state
    t_seq               r_seq, n_seq;
    t_phase             r_phase, n_phase;
    t_field             r_stage, n_stage;
    logic [LEN_W-1:0]   r_out_length, n_out_length;
    logic [7:0]         r_count, n_count;
    logic [7:0]         r_fill, n_fill;
    logic [3:0]         r_width, n_width;
    logic [BUF_W-1:0]   r_buf, n_buf;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [VAL_W-1:0]   r_pend_val, n_pend_val;
    logic [RUN_SHIFT-1:0] r_pend_run, n_pend_run;
    logic [LEN_W-1:0]   r_produced, n_produced;
    logic [NRES_W-1:0]  r_nres, n_nres;
    logic               r_hold_vld, n_hold_vld;
    logic               r_out_vld, n_out_vld;

    // payload
    logic               r_idx_zero, n_idx_zero;
    logic               r_idx_err, n_idx_err;
    t_result            r_cand, n_cand;
    t_result            r_hold, n_hold;
    t_result            r_out, n_out;
    logic               r_out_last, n_out_last;
    logic [VAL_W-1:0]   r_rd_data;

    // value table
    logic [VAL_W-1:0]   mem [TABLE_DEPTH];

    logic               in_beat;
    logic               mem_we;
    logic               start_strm;
    logic               out_free;
    logic               push;
    logic               push_last;
    logic [7:0]         idx_mask;
    logic [7:0]         idx;
    logic [RUN_BITS-1:0] fld;
    logic [VAL_W-1:0]   look_val;

    // shared emit unit: clips the run to what is left of the block
    logic [LEN_W-1:0]   avail;
    logic               over;
    logic [RUN_W-1:0]   run_fix;
    logic [LEN_W-1:0]   produced_new;
    logic               emit_done;

    assign s_axis_tready = (r_seq == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;

    assign idx_mask = 8'((9'd1 << r_width) - 9'd1);
    assign idx      = r_buf[7:0] & idx_mask;
    assign fld      = r_buf[RUN_BITS-1:0];
    assign look_val = r_idx_err ? '0 : r_rd_data;

    assign avail        = r_out_length - r_produced - LEN_W'(1);
    assign over         = {{(LEN_W-RUN_W){1'b0}}, r_cand.run} > avail;
    assign run_fix      = over ? avail[RUN_W-1:0] : r_cand.run;
    assign produced_new = r_produced + LEN_W'(1) + {{(LEN_W-RUN_W){1'b0}}, run_fix};
    assign emit_done    = (produced_new == r_out_length);

    assign mem_we = in_beat && (r_phase == PH_TABLE) && ({1'b0, r_fill} < 9'(TABLE_DEPTH));

    always_comb begin
        n_seq        = r_seq;
        n_phase      = r_phase;
        n_stage      = r_stage;
        n_out_length = i_cfg_wr_en ? i_cfg_wr_data : r_out_length;
        n_count      = r_count;
        n_fill       = r_fill;
        n_width      = r_width;
        n_buf        = r_buf;
        n_cnt        = r_cnt;
        n_pend_val   = r_pend_val;
        n_pend_run   = r_pend_run;
        n_produced   = r_produced;
        n_nres       = r_nres;
        n_hold_vld   = r_hold_vld;
        n_idx_zero   = r_idx_zero;
        n_idx_err    = r_idx_err;
        n_cand       = r_cand;
        n_hold       = r_hold;
        start_strm   = 1'b0;
        push         = 1'b0;
        push_last    = 1'b0;

        case (r_seq)
            S_IDLE: begin
                if (in_beat) begin
                    if (r_phase == PH_TABLE) begin
                        n_fill = r_fill + 8'd1;
                        if (n_fill == r_count) start_strm = 1'b1;
                    end else if (r_phase != PH_STREAM || r_produced >= r_out_length) begin
                        // new block header
                        n_count = s_axis_tdata;
                        n_fill  = 8'd0;
                        n_width = sig_bits(s_axis_tdata - 8'd1);
                        if (s_axis_tdata == 8'd0) begin
                            start_strm = 1'b1;
                        end else begin
                            n_phase = PH_TABLE;
                        end
                    end else begin
                        // bitstream beat: append above the leftover bits
                        n_buf  = r_buf | (BUF_W'(s_axis_tdata) << r_cnt[3:0]);
                        n_cnt  = r_cnt + CNT_W'(8);
                        n_nres = '0;
                        n_seq  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_nres == NRES_W'(MAX_RESULTS)) begin
                    n_seq = S_FLUSH;
                end else if (r_stage == FS_INDEX) begin
                    if (r_cnt < CNT_W'(r_width)) begin
                        n_seq = S_FLUSH;
                    end else begin
                        n_buf      = r_buf >> r_width;
                        n_cnt      = r_cnt - CNT_W'(r_width);
                        n_idx_zero = (idx == 8'd0);
                        n_idx_err  = (idx >= r_count) || ({1'b0, idx} >= 9'(TABLE_DEPTH));
                        n_seq      = S_LOOK;
                    end
                end else begin
                    if (r_cnt < CNT_W'(RUN_BITS)) begin
                        n_seq = S_FLUSH;
                    end else begin
                        n_buf = r_buf >> RUN_BITS;
                        n_cnt = r_cnt - CNT_W'(RUN_BITS);
                        if (r_stage == FS_RUN_LO && fld[RUN_FLAG]) begin
                            // extended run: high bits follow
                            n_pend_run = fld[RUN_SHIFT-1:0];
                            n_stage    = FS_RUN_HI;
                        end else begin
                            n_cand.value = r_pend_val;
                            if (r_stage == FS_RUN_LO) begin
                                n_cand.run = RUN_W'(fld);
                            end else begin
                                n_cand.run = {fld, r_pend_run};
                            end
                            n_cand.done = 1'b0;
                            n_cand.err  = (r_count == 8'd0);
                            n_stage     = FS_INDEX;
                            n_seq       = S_EMIT;
                        end
                    end
                end
            end
            S_LOOK: begin
                // table read data is valid here
                if (r_idx_zero) begin
                    n_pend_val = look_val;
                    n_stage    = FS_RUN_LO;
                    n_seq      = S_SCAN;
                end else begin
                    n_cand.value = look_val;
                    n_cand.run   = '0;
                    n_cand.done  = 1'b0;
                    n_cand.err   = r_idx_err;
                    n_seq        = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_hold_vld || out_free) begin
                    // a held result is not the last one of this beat
                    push         = r_hold_vld;
                    n_hold.value = r_cand.value;
                    n_hold.run   = run_fix;
                    n_hold.done  = emit_done;
                    n_hold.err   = r_cand.err || over;
                    n_hold_vld   = 1'b1;
                    n_produced   = produced_new;
                    n_nres       = r_nres + NRES_W'(1);
                    if (emit_done) begin
                        n_phase = PH_HEAD;
                        n_buf   = '0;
                        n_cnt   = '0;
                        n_stage = FS_INDEX;
                        n_seq   = S_FLUSH;
                    end else begin
                        n_seq = S_SCAN;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_hold_vld) begin
                    n_seq = S_IDLE;
                end else if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    n_hold_vld = 1'b0;
                    n_seq      = S_IDLE;
                end
            end
            default: begin
                n_seq = S_IDLE;
            end
        endcase

        if (start_strm) begin
            n_phase    = (r_out_length == '0) ? PH_HEAD : PH_STREAM;
            n_buf      = '0;
            n_cnt      = '0;
            n_stage    = FS_INDEX;
            n_pend_val = '0;
            n_pend_run = '0;
            n_produced = '0;
        end

        n_out_vld  = push ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_vld);
        n_out      = push ? r_hold : r_out;
        n_out_last = push ? push_last : r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= S_IDLE;
            r_phase      <= PH_HEAD;
            r_stage      <= FS_INDEX;
            r_out_length <= '0;
            r_count      <= '0;
            r_fill       <= '0;
            r_width      <= 4'd8;
            r_buf        <= '0;
            r_cnt        <= '0;
            r_pend_val   <= '0;
            r_pend_run   <= '0;
            r_produced   <= '0;
            r_nres       <= '0;
            r_hold_vld   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_seq        <= n_seq;
            r_phase      <= n_phase;
            r_stage      <= n_stage;
            r_out_length <= n_out_length;
            r_count      <= n_count;
            r_fill       <= n_fill;
            r_width      <= n_width;
            r_buf        <= n_buf;
            r_cnt        <= n_cnt;
            r_pend_val   <= n_pend_val;
            r_pend_run   <= n_pend_run;
            r_produced   <= n_produced;
            r_nres       <= n_nres;
            r_hold_vld   <= n_hold_vld;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx_zero <= n_idx_zero;
        r_idx_err  <= n_idx_err;
        r_cand     <= n_cand;
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    // value table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_fill[TBL_AW-1:0]] <= s_axis_tdata;
        end
        if (r_seq == S_SCAN) begin
            r_rd_data <= mem[idx[TBL_AW-1:0]];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(TDATA_W-VAL_W-RUN_W){1'b0}}, r_out.run, r_out.value};
    assign m_axis_tuser  = {r_out.err, r_out.done};
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: tb/tb_sparse_block_decompressor_unit.sv
// testbench for the sparse block decompressor: directed and random streams vs a behavioral predictor
module tb_sparse_block_decompressor_unit
    import sbd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // cycles a bitstream beat may still be in decode after its last result
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [RUN_W-1:0] run;
        logic             done;
        logic             err;
        logic             last;
    } t_decoded;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]   i_cfg_wr_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;     // [7:0] in_byte
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;          // [7:0] out_value, [18:8] zero_run, rest 0
    logic [TUSER_W-1:0] m_axis_tuser;          // [0] block_done, [1] format_error
    logic               m_axis_tlast;          // last_of_item

    sparse_block_decompressor_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted decoder state
    logic [LEN_W-1:0] want_len = '0;
    t_phase           ph = PH_HEAD;
    logic [7:0]       tbl_count = '0;
    logic [7:0]       tbl_fill = '0;
    logic [7:0]       tbl [TABLE_DEPTH];
    logic [31:0]      bitbuf = '0;
    int               bitcnt = 0;
    t_field           stage = FS_INDEX;
    logic [7:0]       held_value = '0;
    int               held_run = 0;
    logic [LEN_W-1:0] made = '0;

    t_decoded expected_decodes[$];
    int       mismatches = 0;
    int       sent_bytes = 0;
    bit       steady = 1'b0;      // no idling on either side
    int       stall_left = 0;

    // index width: significant bits of (count - 1) mod 256
    function automatic int index_width(input logic [7:0] cnt);
        logic [7:0] v;
        int         w;
        v = cnt - 8'd1;
        w = 0;
        while (v != 0) begin
            w++;
            v = v >> 1;
        end
        return w;
    endfunction

    function automatic int pull_bits(input int w);
        int f;
        f = int'(bitbuf & ((32'd1 << w) - 32'd1));
        bitbuf = (bitbuf >> w) & 32'h0000_FFFF;
        bitcnt -= w;
        return f;
    endfunction

    function automatic void open_stream();
        ph = PH_STREAM;
        bitbuf = '0;
        bitcnt = 0;
        stage = FS_INDEX;
        held_value = '0;
        held_run = 0;
        made = '0;
        // zero length: no bitstream, straight back to a header
        if (want_len == 0) ph = PH_HEAD;
    endfunction

    function automatic void take_count(input logic [7:0] b);
        tbl_count = b;
        tbl_fill = '0;
        if (b == 0) open_stream();
        else ph = PH_TABLE;
    endfunction

    // one decoded byte plus its zero run, clipped to what is left of the block
    function automatic t_decoded make_result(input logic [7:0] v, input int run,
                                             input logic err);
        t_decoded r;
        int       room;
        room = int'(want_len) - int'(made) - 1;
        if (run > room) begin
            err = 1'b1;
            run = room;
        end
        made = made + LEN_W'(1 + run);
        r.value = v;
        r.run = run[RUN_W-1:0];
        r.done = (made == want_len);
        r.err = err;
        r.last = 1'b0;
        return r;
    endfunction

    // works out the results caused by one compressed byte
    task automatic decode_byte(input logic [7:0] b);
        t_decoded got[$];
        t_decoded r;
        int       width;
        int       idx;
        int       fld;
        logic     bad;
        if (ph == PH_TABLE) begin
            tbl[tbl_fill] = b;
            tbl_fill = tbl_fill + 8'd1;
            if (tbl_fill == tbl_count) open_stream();
            return;
        end
        // a finished or shortened block takes this byte as the next header
        if (ph != PH_STREAM || made >= want_len) begin
            take_count(b);
            return;
        end
        bitbuf = bitbuf | (32'(b) << (bitcnt & 15));
        bitcnt += 8;
        width = index_width(tbl_count);
        while (got.size() < MAX_RESULTS) begin
            if (stage == FS_INDEX) begin
                if (bitcnt < width) break;
                idx = pull_bits(width);
                bad = (idx >= int'(tbl_count));
                // index 0 still reads its run field, even when out of range
                if (idx == 0) begin
                    held_value = bad ? 8'h00 : tbl[0];
                    stage = FS_RUN_LO;
                    continue;
                end
                r = make_result(bad ? 8'h00 : tbl[idx], 0, bad);
            end else begin
                if (bitcnt < RUN_BITS) break;
                fld = pull_bits(RUN_BITS);
                if (stage == FS_RUN_LO && fld[RUN_FLAG]) begin
                    held_run = fld & ((1 << RUN_SHIFT) - 1);
                    stage = FS_RUN_HI;
                    continue;
                end
                if (stage == FS_RUN_LO)
                    r = make_result(held_value, fld, tbl_count == 0);
                else
                    r = make_result(held_value, held_run | (fld << RUN_SHIFT), tbl_count == 0);
                stage = FS_INDEX;
            end
            got.push_back(r);
            if (r.done) begin
                // leftover bits of the byte are dropped
                ph = PH_HEAD;
                bitbuf = '0;
                bitcnt = 0;
                stage = FS_INDEX;
                break;
            end
        end
        if (got.size() > 0) got[got.size()-1].last = 1'b1;
        foreach (got[i]) expected_decodes.push_back(got[i]);
    endtask

    // one compressed byte, with an occasional gap before it
    task automatic send_byte(input logic [7:0] b);
        decode_byte(b);
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_bytes++;
    endtask

    // out_length is written only with nothing in flight
    task automatic set_out_length(input logic [LEN_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (expected_decodes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        want_len = v;
    endtask

    // header, random table, random bitstream until the block ends;
    // a cut block has its length lowered to at most what it already made
    task automatic feed_block(input int cnt, input bit cut);
        int n;
        bit again;
        do begin
            again = 1'b0;
            send_byte(cnt[7:0]);
            repeat (cnt) send_byte(8'($urandom_range(0, 255)));
            n = 0;
            while (ph == PH_STREAM && made < want_len && n < 80) begin
                if (cut && made > 0) begin
                    set_out_length(LEN_W'($urandom_range(0, made)));
                    cnt = $urandom_range(1, 6);
                    cut = 1'b0;
                    again = 1'b1;
                    break;
                end
                send_byte(8'($urandom_range(0, 255)));
                n++;
            end
        end while (again);
    endtask

    task automatic random_blocks(input int items);
        int stop_at;
        int cnt;
        int len;
        stop_at = sent_bytes + items;
        while (sent_bytes < stop_at) begin
            case ($urandom_range(0, 19))
                0: begin
                    cnt = 0;
                end
                1, 2, 3, 4: begin
                    cnt = 1;
                end
                5, 6, 7, 8: begin
                    cnt = 2;
                end
                9: begin
                    cnt = $urandom_range(9, 64);
                end
                default: begin
                    cnt = $urandom_range(3, 8);
                end
            endcase
            // long blocks only where runs make them short in bytes
            if (cnt > 0 && cnt <= 2 && $urandom_range(0, 2) == 0)
                len = $urandom_range(64, 4000);
            else if ($urandom_range(0, 11) == 0)
                len = 0;
            else
                len = $urandom_range(1, (cnt == 0) ? 8 : 40);
            set_out_length(len[LEN_W-1:0]);
            feed_block(cnt, $urandom_range(0, 6) == 0);
        end
    endtask

    // zero length: table completes, no bitstream, next byte is a header
    task automatic test_zero_length();
        set_out_length(16'd0);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);   // empty table under zero length
    endtask

    // one-entry table: zero-bit indices, longest run, then length lowered mid-block
    task automatic test_long_runs();
        set_out_length(16'hFFFF);
        send_byte(8'h01);
        send_byte(8'h7E);
        send_byte(8'hFF);   // extended run field, high part pending
        send_byte(8'hFF);   // run of 2047
        send_byte(8'h00);   // two short runs from one beat
        set_out_length(16'd100);
    endtask

    // out-of-range index, all table slots, then a run that overflows the block
    task automatic test_index_errors();
        set_out_length(16'd20);
        send_byte(8'h03);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'h27);   // indices 3, 1, 2, 0
        send_byte(8'hFF);
        send_byte(8'h00);   // run 127 clipped to 16
    endtask

    // count 0: eight-bit indices, every one out of range
    task automatic test_empty_table();
        set_out_length(16'd3);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h05);
    endtask

    // two-entry table: one-bit indices, eight results from one beat
    task automatic test_one_bit_indices();
        set_out_length(16'd8);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
    endtask

    task automatic test_random_idling();
        random_blocks(170);
    endtask

    task automatic test_random_steady();
        steady = 1'b1;
        random_blocks(50);
    endtask

    // result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_decoded want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: tdata=%h tuser=%b tlast=%b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want = expected_decodes.pop_front();
                if (m_axis_tdata[7:0] !== want.value ||
                    m_axis_tdata[18:8] !== want.run ||
                    m_axis_tdata[TDATA_W-1:19] !== '0 ||
                    m_axis_tuser[0] !== want.done ||
                    m_axis_tuser[1] !== want.err ||
                    m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: exp value=%h run=%0d done=%b err=%b last=%b",
                               want.value, want.run, want.done, want.err, want.last);
                        $display(" / got value=%h run=%0d pad=%h done=%b err=%b last=%b",
                                 m_axis_tdata[7:0], m_axis_tdata[18:8],
                                 m_axis_tdata[TDATA_W-1:19], m_axis_tuser[0],
                                 m_axis_tuser[1], m_axis_tlast);
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_length();
        test_long_runs();
        test_index_errors();
        test_empty_table();
        test_one_bit_indices();
        test_random_idling();
        test_random_steady();
        s_axis_tvalid <= 1'b0;
        while (expected_decodes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_decodes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
